// ===== rtl/cfilt_pkg.sv =====
package cfilt_pkg;

  // Default number of CORDIC micro-rotations and the size of the arctangent table.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // Field and datapath widths.
  localparam int IN_W    = 16;  // raw sensor sample
  localparam int OUT_W   = 17;  // output angle, 1/256 degree
  localparam int ANG_W   = 32;  // kept angle, 2^-16 degree
  localparam int WGT_W   = 16;  // blend weights
  localparam int SCL_W   = 20;  // gyro step scale
  localparam int CDC_W   = 27;  // CORDIC x/y datapath
  localparam int ZW      = 26;  // CORDIC angle accumulator
  localparam int STEP_IW = $clog2(ATAN_LEN + 1);
  localparam int ATAN_W  = 22;

  // Quarter turn in 2^-16 degree.
  localparam logic signed [ZW-1:0] DEG90 = ZW'(5898240);

  // Configuration register indexes.
  localparam logic [1:0] CFG_RATE_WT    = 2'd0;
  localparam logic [1:0] CFG_GRAV_WT    = 2'd1;
  localparam logic [1:0] CFG_STEP_SCALE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_MUL_GYRO,
    ST_SUM,
    ST_MUL_WEIGHT,
    ST_MUL_TILT,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_GYRO,
    MUL_WEIGHT,
    MUL_TILT
  } mul_sel_t;

  typedef struct packed {
    logic     cordic_load;
    logic     cordic_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_en;
    logic     acc_en;
    logic     finish_en;
    logic     axis;
    logic     out_load;
  } ctrl_t;

  // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_IW-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234378;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cfilt_cordic.sv =====
module cfilt_cordic import cfilt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   step,
  input  logic signed [IN_W-1:0] y_in,
  input  logic signed [IN_W-1:0] x_in,
  output logic signed [ZW-1:0]   z,
  output logic                   done
);

  localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [STEP_IW-1:0] LAST_STEP = STEP_IW'(STEPS_EFF);

  logic signed [CDC_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]    z_r, z_nxt;
  logic [STEP_IW-1:0]      i_r, i_nxt;
  logic                    zero_r, zero_nxt;
  logic signed [CDC_W-1:0] xs, ys, dx, dy;
  logic signed [ZW-1:0]    at;

  always_comb begin
    xs = {{(CDC_W-IN_W-8){x_in[IN_W-1]}}, x_in, 8'h00};
    ys = {{(CDC_W-IN_W-8){y_in[IN_W-1]}}, y_in, 8'h00};
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = signed'(ZW'(atan_entry(i_r)));
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    zero_nxt = zero_r;
    if (load) begin
      zero_nxt = (x_in == '0) && (y_in == '0);
      i_nxt    = '0;
      // A vector in the left half plane is first turned by a quarter turn.
      if (xs < 0) begin
        if (ys >= 0) begin
          x_nxt = ys;
          y_nxt = -xs;
          z_nxt = DEG90;
        end else begin
          x_nxt = -ys;
          y_nxt = xs;
          z_nxt = -DEG90;
        end
      end else begin
        x_nxt = xs;
        y_nxt = ys;
        z_nxt = '0;
      end
    end else if (step) begin
      i_nxt = i_r + 1'b1;
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r    <= '0;
      zero_r <= 1'b0;
    end else begin
      i_r    <= i_nxt;
      zero_r <= zero_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign done = (i_r == LAST_STEP);
  assign z    = zero_r ? '0 : z_r;

  a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !done)
    else $error("CORDIC stepped past its last iteration");

endmodule

// ===== rtl/cfilt_blend.sv =====
module cfilt_blend import cfilt_pkg::*; (
  input  logic                    clk,
  input  ctrl_t                   ctl,
  input  logic signed [IN_W-1:0]  gyro,
  input  logic signed [ZW-1:0]    tilt,
  input  logic signed [ANG_W-1:0] angle,
  input  logic [WGT_W-1:0]        rate_wt,
  input  logic [WGT_W-1:0]        grav_wt,
  input  logic [SCL_W-1:0]        step_scale,
  output logic signed [ANG_W-1:0] result
);

  localparam int MA_W  = 34;
  localparam int MB_W  = SCL_W + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int SUM_W = 50;
  localparam int ACC_W = P_W + 1;

  localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(32768);
  localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] MAX32  = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] MIN32  = ACC_W'(-64'sd2147483648);

  logic signed [MA_W-1:0]  ma, s16_r, s16_nxt;
  logic signed [MB_W-1:0]  mb;
  logic signed [P_W-1:0]   prod_r, acc_r;
  logic signed [SUM_W-1:0] s;
  logic signed [ACC_W-1:0] tot, r;

  always_comb begin
    case (ctl.mul_sel)
      MUL_GYRO: begin
        ma = MA_W'(gyro);
        mb = signed'({1'b0, step_scale});
      end
      MUL_WEIGHT: begin
        ma = s16_r;
        mb = signed'(MB_W'(rate_wt));
      end
      MUL_TILT: begin
        ma = MA_W'(tilt);
        mb = signed'(MB_W'(grav_wt));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Gyro-integrated angle, rounded from 2^-32 to 2^-16 degree.
  always_comb begin
    s       = (SUM_W'(angle) <<< 16) + SUM_W'(prod_r);
    s16_nxt = MA_W'((s + HALF_S) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) prod_r <= ma * mb;
    if (ctl.sum_en) s16_r <= s16_nxt;
    if (ctl.acc_en) acc_r <= prod_r;
  end

  always_comb begin
    tot = ACC_W'(acc_r) + ACC_W'(prod_r) + HALF_A;
    r   = tot >>> 16;
    if (r > MAX32) begin
      result = ANG_W'(MAX32);
    end else if (r < MIN32) begin
      result = ANG_W'(MIN32);
    end else begin
      result = r[ANG_W-1:0];
    end
  end

endmodule

// ===== rtl/cfilt_ctrl.sv =====
module cfilt_ctrl import cfilt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_valid,
  input  logic  out_ready,
  input  logic  cordic_done,
  output logic  in_ready,
  output ctrl_t ctl
);

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
          axis_nxt  = 1'b0;
        end
      end
      ST_LOAD:       state_nxt = ST_RUN;
      ST_RUN:        if (cordic_done) state_nxt = ST_MUL_GYRO;
      ST_MUL_GYRO:   state_nxt = ST_SUM;
      ST_SUM:        state_nxt = ST_MUL_WEIGHT;
      ST_MUL_WEIGHT: state_nxt = ST_MUL_TILT;
      ST_MUL_TILT:   state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!axis_r) begin
          state_nxt = ST_LOAD;
          axis_nxt  = 1'b1;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT:        if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.mul_sel  = MUL_GYRO;
    ctl.axis     = axis_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE:       in_ready = 1'b1;
      ST_LOAD:       ctl.cordic_load = 1'b1;
      ST_RUN:        ctl.cordic_step = !cordic_done;
      ST_MUL_GYRO: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_GYRO;
      end
      ST_SUM:        ctl.sum_en = 1'b1;
      ST_MUL_WEIGHT: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_WEIGHT;
      end
      ST_MUL_TILT: begin
        ctl.acc_en  = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_TILT;
      end
      ST_FINISH:     ctl.finish_en = 1'b1;
      ST_OUT:        ctl.out_load = !out_valid || out_ready;
      default:       in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

// ===== rtl/tilt_complementary_filter.sv =====
// Channel  Direction  Handshake                Payload
// in_      input      in_valid / in_ready      accel_x, accel_y, accel_z, gyro_x, gyro_y
// out_     output     out_valid / out_ready    angle_x, angle_y (1/256 degree)
// cfg_     input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each axis runs a load, the rotations, a check for the end of the run and five
// multiply and sum steps. With the idle and output steps, one sample runs through
// both axes in turn, X first and then Y, before its result is loaded into the
// output register.
// A new sample is taken only when idle; if the previous result is still waiting in the
// output register, the block holds in its output step until that result is transferred.
// Reset is synchronous and active low; it restores the register defaults and clears both
// kept angles. Configuration writes are always taken.
module tilt_complementary_filter import cfilt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  in_accel_x,
  input  logic signed [IN_W-1:0]  in_accel_y,
  input  logic signed [IN_W-1:0]  in_accel_z,
  input  logic signed [IN_W-1:0]  in_gyro_x,
  input  logic signed [IN_W-1:0]  in_gyro_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_angle_x,
  output logic signed [OUT_W-1:0] out_angle_y,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [SCL_W-1:0]        cfg_data
);

  ctrl_t ctl;

  // Captured sample. It is held for the whole computation because the
  // source is free to change its payload after the transfer.
  logic signed [IN_W-1:0] ax_r, ay_r, az_r, gx_r, gy_r;

  // Configuration registers.
  logic [WGT_W-1:0] rate_wt_r, grav_wt_r;
  logic [SCL_W-1:0] step_scale_r;

  // Kept filter angles in 2^-16 degree.
  logic signed [ANG_W-1:0] tilt_x_r, tilt_y_r;

  logic signed [OUT_W-1:0] angle_x_r, angle_y_r;
  logic                    out_valid_r;

  logic signed [ZW-1:0]    tilt;
  logic                    cordic_done;
  logic signed [ANG_W-1:0] blend_result;
  logic signed [IN_W-1:0]  gyro_sel, accel_sel;
  logic signed [ANG_W-1:0] angle_sel;
  logic                    in_xfer, out_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  // The axis bit picks which accelerometer component is measured against Z
  // and which gyro rate and kept angle go into the blend.
  assign accel_sel = ctl.axis ? ay_r : ax_r;
  assign gyro_sel  = ctl.axis ? gy_r : gx_r;
  assign angle_sel = ctl.axis ? tilt_y_r : tilt_x_r;

  cfilt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .out_valid   (out_valid_r),
    .out_ready   (out_ready),
    .cordic_done (cordic_done),
    .in_ready    (in_ready),
    .ctl         (ctl)
  );

  cfilt_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (ctl.cordic_load),
    .step  (ctl.cordic_step),
    .y_in  (accel_sel),
    .x_in  (az_r),
    .z     (tilt),
    .done  (cordic_done)
  );

  cfilt_blend u_blend (
    .clk        (clk),
    .ctl        (ctl),
    .gyro       (gyro_sel),
    .tilt       (tilt),
    .angle      (angle_sel),
    .rate_wt    (rate_wt_r),
    .grav_wt    (grav_wt_r),
    .step_scale (step_scale_r),
    .result     (blend_result)
  );

  // Output scaling: drop eight fraction bits rounding toward minus infinity,
  // then clamp to the 17-bit output range.
  function automatic logic signed [OUT_W-1:0] out_scale(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    logic signed [OUT_W-1:0] v;
    t = a >>> 8;
    if (t > ANG_W'(65535)) begin
      v = OUT_W'(65535);
    end else if (t < -ANG_W'(65536)) begin
      v = OUT_W'(-65536);
    end else begin
      v = t[OUT_W-1:0];
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      gx_r <= in_gyro_x;
      gy_r <= in_gyro_y;
    end
    if (ctl.out_load) begin
      angle_x_r <= out_scale(tilt_x_r);
      angle_y_r <= out_scale(tilt_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_wt_r    <= WGT_W'(64225);
      grav_wt_r    <= WGT_W'(1311);
      step_scale_r <= SCL_W'(32786);
      tilt_x_r     <= '0;
      tilt_y_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // Writes to an index beyond the register list are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RATE_WT:    rate_wt_r    <= cfg_data[WGT_W-1:0];
          CFG_GRAV_WT:    grav_wt_r    <= cfg_data[WGT_W-1:0];
          CFG_STEP_SCALE: step_scale_r <= cfg_data;
          default:        step_scale_r <= step_scale_r;
        endcase
      end
      if (ctl.finish_en) begin
        if (ctl.axis) begin
          tilt_y_r <= blend_result;
        end else begin
          tilt_x_r <= blend_result;
        end
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_angle_x = angle_x_r;
  assign out_angle_y = angle_y_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_tilt_x_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(ctl.finish_en && !ctl.axis)) |=> $stable(tilt_x_r))
    else $error("X angle changed outside its update step");

  a_tilt_y_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(ctl.finish_en && ctl.axis)) |=> $stable(tilt_y_r))
    else $error("Y angle changed outside its update step");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import cfilt_pkg::*;

  // One raw inertial reading as it is presented on the input channel.
  typedef struct {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] gx;
    logic signed [IN_W-1:0] gy;
  } reading_t;

  // The pair of filtered angles that one reading should produce.
  typedef struct {
    logic signed [OUT_W-1:0] ang_x;
    logic signed [OUT_W-1:0] ang_y;
  } angle_pair_t;

  // Handshake pacing patterns that the phases step through.
  typedef enum {PACE_STEADY, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

  // Flavors of random readings. CLIMB and DIVE push both kept angles hard toward
  // the positive or negative limit so that both saturation stages are reached.
  typedef enum {MIX_GENERAL, MIX_CLIMB, MIX_DIVE} mix_t;

  // The register map has three entries, so the last index is unused and a write
  // to it must leave every register alone.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Settling wait, based on the time one sample occupies at the default CORDIC length.
  localparam int LATENCY = 2 * (CORDIC_STEPS_DEF + 7) + 2;
  localparam int N_ROT = (CORDIC_STEPS_DEF < ATAN_LEN) ? CORDIC_STEPS_DEF : ATAN_LEN;
  localparam int CYCLE_LIMIT = 1000000;

  // Reset values of the three registers.
  localparam int unsigned RATE_WT_DEF = 64225;
  localparam int unsigned GRAV_WT_DEF = 1311;
  localparam int unsigned STEP_SCALE_DEF = 32786;
  localparam int unsigned WEIGHT_MAX = 65535;
  localparam int unsigned STEP_SCALE_MAX = 1048575;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [IN_W-1:0]  in_accel_x = '0;
  logic signed [IN_W-1:0]  in_accel_y = '0;
  logic signed [IN_W-1:0]  in_accel_z = '0;
  logic signed [IN_W-1:0]  in_gyro_x = '0;
  logic signed [IN_W-1:0]  in_gyro_y = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_angle_x;
  logic signed [OUT_W-1:0] out_angle_y;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = '0;
  logic [SCL_W-1:0]        cfg_data = '0;

  tilt_complementary_filter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_accel_x  (in_accel_x),
    .in_accel_y  (in_accel_y),
    .in_accel_z  (in_accel_z),
    .in_gyro_x   (in_gyro_x),
    .in_gyro_y   (in_gyro_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_angle_x (out_angle_x),
    .out_angle_y (out_angle_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // The clock runs at a period of 10 time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor. These variables mirror the block's registers and its two
  // kept angles. They start at the reset values and change only on a completed
  // register write or an accepted reading.
  // ---------------------------------------------------------------------------
  int unsigned wt_gyro = RATE_WT_DEF;
  int unsigned wt_accel = GRAV_WT_DEF;
  int unsigned step_scale = STEP_SCALE_DEF;
  int          kept_x = 0;
  int          kept_y = 0;

  // Arctangent of 2^-i, in 2^-16 degree, rounded to nearest.
  longint atan_lut [0:ATAN_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Readings waiting to be sent, and angle pairs waiting to come back.
  reading_t    pending_readings[$];
  angle_pair_t expected_angles[$];

  int queued_total = 0;
  int accepted_total = 0;
  int results_checked = 0;
  int errors = 0;
  int settings_used = 1;
  int cycles = 0;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int send_gap_pct = 0;
  int stall_pct = 0;

  // Tilt of the vector (den, num) as atan2(num, den), in 2^-16 degree. A vector
  // in the left half plane is first turned a quarter turn toward the right half
  // plane; the vectoring iterations then drive the y component toward zero.
  // Arithmetic right shifts on signed 64-bit values round toward minus infinity.
  function automatic longint tilt_deg16(longint num, longint den);
    longint xr;
    longint yr;
    longint zr;
    longint tmp;
    longint dx;
    longint dy;
    if (num == 0 && den == 0) begin
      return 0;
    end
    xr = den * 256;
    yr = num * 256;
    zr = 0;
    if (xr < 0) begin
      if (yr >= 0) begin
        tmp = xr;
        xr = yr;
        yr = -tmp;
        zr = longint'(DEG90);
      end else begin
        tmp = xr;
        xr = -yr;
        yr = tmp;
        zr = -longint'(DEG90);
      end
    end
    for (int i = 0; i < N_ROT; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr > 0) begin
        xr = xr + dx;
        yr = yr - dy;
        zr = zr + atan_lut[i];
      end else begin
        xr = xr - dx;
        yr = yr + dy;
        zr = zr - atan_lut[i];
      end
    end
    return zr;
  endfunction

  // One complementary-filter update for a single axis. The gyro term is added at
  // 2^-32 degree and rounded back to 2^-16 degree, then the weighted blend is
  // rounded half up and clamped to the 32-bit range of the kept angle.
  function automatic int blend_axis(int angle, longint rate, longint tilt);
    longint sum_fine;
    longint sum_deg16;
    longint acc;
    longint r;
    sum_fine = longint'(angle) * 65536 + rate * longint'(step_scale);
    sum_deg16 = (sum_fine + 32768) >>> 16;
    acc = sum_deg16 * longint'(wt_gyro) + tilt * longint'(wt_accel);
    r = (acc + 32768) >>> 16;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end
    if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return int'(r);
  endfunction

  // Kept angle to the 1/256-degree output, floored and saturated.
  function automatic logic signed [OUT_W-1:0] angle_to_out(int a);
    longint v;
    v = longint'(a) >>> 8;
    if (v > 65535) begin
      v = 65535;
    end
    if (v < -65536) begin
      v = -65536;
    end
    return v[OUT_W-1:0];
  endfunction

  // Advance the predictor by one accepted reading and queue its angle pair.
  task automatic predict_angles(input reading_t r);
    angle_pair_t p;
    kept_x = blend_axis(kept_x, r.gx, tilt_deg16(r.ax, r.az));
    kept_y = blend_axis(kept_y, r.gy, tilt_deg16(r.ay, r.az));
    p.ang_x = angle_to_out(kept_x);
    p.ang_y = angle_to_out(kept_y);
    expected_angles.push_back(p);
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. At each rising edge it first notes whether the reading on the
  // port was transferred, and only then decides what the port carries next, so
  // in_valid receives at most one nonblocking assignment per edge. Once valid is
  // raised the payload stays put until the transfer.
  // ---------------------------------------------------------------------------
  reading_t on_port;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_angles(on_port);
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (pending_readings.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          on_port = pending_readings.pop_front();
          in_accel_x <= on_port.ax;
          in_accel_y <= on_port.ay;
          in_accel_z <= on_port.az;
          in_gyro_x <= on_port.gx;
          in_gyro_y <= on_port.gy;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor. Each transfer on the result channel is compared with the
  // oldest outstanding prediction. The ready line is redrawn every cycle from
  // the current stall rate.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    angle_pair_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          flag_error($sformatf("result with nothing outstanding: x=%0d y=%0d",
                               out_angle_x, out_angle_y));
        end else begin
          want = expected_angles.pop_front();
          results_checked++;
          if (out_angle_x !== want.ang_x || out_angle_y !== want.ang_y) begin
            flag_error($sformatf("result %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                                 results_checked, want.ang_x, want.ang_y,
                                 out_angle_x, out_angle_y));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d of %0d readings transferred",
               cycles, accepted_total, queued_total);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic add_reading(input int ax, input int ay, input int az,
                             input int gx, input int gy);
    reading_t r;
    r.ax = IN_W'(ax);
    r.ay = IN_W'(ay);
    r.az = IN_W'(az);
    r.gx = IN_W'(gx);
    r.gy = IN_W'(gy);
    pending_readings.push_back(r);
    queued_total++;
  endtask

  // A value from the ends of the 16-bit range or right around zero.
  function automatic logic signed [IN_W-1:0] extreme_pick();
    case ($urandom_range(5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic reading_t make_reading(mix_t mix);
    reading_t r;
    int pick;
    pick = $urandom_range(99);
    r.ax = 16'($urandom);
    r.ay = 16'($urandom);
    r.az = 16'($urandom);
    r.gx = 16'($urandom);
    r.gy = 16'($urandom);
    if (mix == MIX_CLIMB) begin
      // Small positive axis over a strongly negative Z sits near +180 degrees.
      r.ax = 16'($urandom_range(100));
      r.ay = 16'($urandom_range(100));
      r.az = 16'(-int'($urandom_range(32768, 30000)));
      r.gx = 16'($urandom_range(32767, 30000));
      r.gy = 16'($urandom_range(32767, 30000));
    end else if (mix == MIX_DIVE) begin
      r.ax = 16'(-int'($urandom_range(100, 1)));
      r.ay = 16'(-int'($urandom_range(100, 1)));
      r.az = 16'(-int'($urandom_range(32768, 30000)));
      r.gx = 16'(-int'($urandom_range(32768, 30000)));
      r.gy = 16'(-int'($urandom_range(32768, 30000)));
    end else if (pick < 50) begin
      // Fully random fields, already drawn above.
    end else if (pick < 65) begin
      // Accelerometer right around zero, including the all-zero vector.
      r.ax = 16'(int'($urandom_range(8)) - 4);
      r.ay = 16'(int'($urandom_range(8)) - 4);
      r.az = 16'(int'($urandom_range(8)) - 4);
    end else if (pick < 75) begin
      // Sensor upside down: the quarter-turn pre-rotation path.
      r.az = 16'(-int'($urandom_range(32768, 1)));
    end else if (pick < 85) begin
      r.ax = extreme_pick();
      r.ay = extreme_pick();
      r.az = extreme_pick();
      r.gx = extreme_pick();
      r.gy = extreme_pick();
    end else begin
      // Something like a real board: about 1 g on Z, modest tilt and rotation.
      r.ax = 16'(int'($urandom_range(16000)) - 8000);
      r.ay = 16'(int'($urandom_range(16000)) - 8000);
      r.az = 16'(16384 + int'($urandom_range(4000)) - 2000);
      r.gx = 16'(int'($urandom_range(1000)) - 500);
      r.gy = 16'(int'($urandom_range(1000)) - 500);
    end
    return r;
  endfunction

  // Register write through the configuration channel. The predictor takes the
  // new value at the same edge as the transfer and keeps only the bits that the
  // register holds.
  task automatic write_reg(input logic [1:0] idx, input logic [SCL_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RATE_WT:    wt_gyro = 32'(data[WGT_W-1:0]);
      CFG_GRAV_WT:    wt_accel = 32'(data[WGT_W-1:0]);
      CFG_STEP_SCALE: step_scale = 32'(data);
      default: ;
    endcase
  endtask

  task automatic load_filter(input int unsigned gw, input int unsigned aw,
                             input int unsigned scale);
    write_reg(CFG_RATE_WT, SCL_W'(gw));
    write_reg(CFG_GRAV_WT, SCL_W'(aw));
    write_reg(CFG_STEP_SCALE, SCL_W'(scale));
    settings_used++;
  endtask

  // Queue a batch of readings under the given pacing, then wait until every
  // reading has been transferred and every angle pair has come back. The short
  // settle afterward keeps the next register write clear of the block.
  task automatic run_phase(input pace_t pace, input mix_t mix, input int count);
    case (pace)
      PACE_STEADY:      begin send_gap_pct = 0;  stall_pct = 0;  end
      PACE_SEND_GAPS:   begin send_gap_pct = 80; stall_pct = 0;  end
      PACE_RECV_STALLS: begin send_gap_pct = 0;  stall_pct = 80; end
      default:          begin send_gap_pct = 27; stall_pct = 27; end
    endcase
    repeat (count) begin
      pending_readings.push_back(make_reading(mix));
      queued_total++;
    end
    while (accepted_total != queued_total || expected_angles.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed readings under the reset defaults: the zero vector, each axis on
    // the Z=0 line, the upside-down cases on both sides of 180 degrees, the
    // ends of every field, and pure gyro motion.
    add_reading(0, 0, 0, 0, 0);
    add_reading(0, 0, 16384, 0, 0);
    add_reading(16384, -16384, 0, 0, 0);
    add_reading(0, 0, -16384, 0, 0);
    add_reading(100, -100, -16384, 0, 0);
    add_reading(-32768, 32767, -32768, 0, 0);
    add_reading(32767, -32768, 32767, 0, 0);
    add_reading(-32768, -32768, -32768, -32768, -32768);
    add_reading(32767, 32767, 32767, 32767, 32767);
    add_reading(1, -1, -1, 32767, -32768);
    add_reading(-1, 1, 1, -32768, 32767);
    add_reading(0, 0, 0, 32767, 32767);
    add_reading(0, 0, 0, -32768, -32768);
    add_reading(1, 0, 0, 0, 0);
    add_reading(-1, -1, 0, 1, -1);
    add_reading(5, -5, -32768, 100, -100);
    run_phase(PACE_STEADY, MIX_GENERAL, 120);

    // Gyro path only, at full weight and the largest step.
    load_filter(WEIGHT_MAX, 0, STEP_SCALE_MAX);
    run_phase(PACE_SEND_GAPS, MIX_GENERAL, 100);

    // Both weights at full scale: the angle climbs into output saturation and
    // then into the 32-bit clamp of the kept angle.
    load_filter(WEIGHT_MAX, WEIGHT_MAX, STEP_SCALE_MAX);
    run_phase(PACE_STEADY, MIX_CLIMB, 190);

    // Zero gyro weight throws the history away; only the tilt remains.
    load_filter(0, WEIGHT_MAX, 0);
    run_phase(PACE_BOTH, MIX_GENERAL, 100);

    // Same push as before, toward the negative limits.
    load_filter(WEIGHT_MAX, WEIGHT_MAX, STEP_SCALE_MAX);
    run_phase(PACE_RECV_STALLS, MIX_DIVE, 190);

    // Weight writes with junk above bit 15 must keep only the low half, and a
    // write to the unused index must change nothing.
    write_reg(CFG_RATE_WT, 20'hF8000);
    write_reg(CFG_GRAV_WT, 20'hA8000);
    write_reg(CFG_STEP_SCALE, SCL_W'($urandom));
    write_reg(CFG_UNUSED, SCL_W'($urandom));
    settings_used++;
    run_phase(PACE_RECV_STALLS, MIX_GENERAL, 150);

    // Back to the defaults by explicit writes.
    load_filter(RATE_WT_DEF, GRAV_WT_DEF, STEP_SCALE_DEF);
    run_phase(PACE_SEND_GAPS, MIX_GENERAL, 150);

    load_filter($urandom_range(WEIGHT_MAX), $urandom_range(WEIGHT_MAX),
                $urandom_range(STEP_SCALE_MAX));
    run_phase(PACE_BOTH, MIX_GENERAL, 150);

    // Give any stray result time to show up before the verdict.
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_angles.size() != 0) begin
      flag_error($sformatf("%0d angle pairs never arrived", expected_angles.size()));
    end

    $display("Covered %0d readings under %0d register settings and four pacing patterns,",
             accepted_total, settings_used);
    $display("with %0d angle pairs compared and %0d errors found.", results_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== tilt_complementary_filter.f =====
rtl/cfilt_pkg.sv
rtl/cfilt_cordic.sv
rtl/cfilt_blend.sv
rtl/cfilt_ctrl.sv
rtl/tilt_complementary_filter.sv
dv/tb_top.sv
